### rtl/sapt_pkg.sv
// Shared types and constants for the sensor alert persistence tracker.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package sapt_pkg;

    localparam int unsigned COUNT_W        = 8;
    localparam int unsigned LEARN_LIMIT_W  = 27;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

    typedef enum logic [1:0] {
        LEVEL_NONE      = 2'd0,
        LEVEL_WATCH     = 2'd1,
        LEVEL_WARNING   = 2'd2,
        LEVEL_CONFIRMED = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        REG_MULTIPLIER   = 3'd0,
        REG_PERSISTENCE  = 3'd1,
        REG_HOLD_SECONDS = 3'd2,
        REG_LEARN_DAYS   = 3'd3,
        REG_TURB_LIMIT   = 3'd4,
        REG_SOLIDS_LIMIT = 3'd5
    } reg_index_t;

    localparam logic [7:0]  MULTIPLIER_RESET   = 8'd48;
    localparam logic [7:0]  PERSISTENCE_RESET  = 8'd3;
    localparam logic [15:0] HOLD_RESET         = 16'd3600;
    localparam logic [26:0] LEARN_LIMIT_RESET  = 27'd2592000;
    localparam logic [14:0] TURB_LIMIT_RESET   = 15'd80;
    localparam logic [14:0] SOLIDS_LIMIT_RESET = 15'd16000;

    // Configuration as seen by the datapath; the learning window is held
    // pre-scaled to seconds.
    typedef struct packed {
        logic [7:0]               multiplier;
        logic [COUNT_W-1:0]       persistence;
        logic [15:0]              hold_seconds;
        logic [LEARN_LIMIT_W-1:0] learn_limit;
        logic [14:0]              turb_limit;
        logic [14:0]              solids_limit;
    } cfg_t;

    typedef struct packed {
        logic update;
        logic learning_open;
    } chan_ctrl_t;

endpackage

### rtl/sapt_channel.sv
// One sensor channel: anomaly test, saturating run count and stored level.
// Depends on sapt_pkg.
module sapt_channel
(
    input  logic                clk,
    input  logic                rst_n,
    input  sapt_pkg::chan_ctrl_t ctrl,
    input  sapt_pkg::cfg_t      cfg,
    input  logic [14:0]         limit,
    input  logic signed [15:0]  reading,
    input  logic signed [15:0]  mean,
    output sapt_pkg::level_t    level
);

    logic [sapt_pkg::COUNT_W-1:0] count_reg;
    logic [sapt_pkg::COUNT_W-1:0] count_next;
    sapt_pkg::level_t             level_reg;
    sapt_pkg::level_t             level_next;

    logic signed [25:0] scaled;
    logic signed [25:0] thr;
    logic               over_mean;
    logic               over_limit;
    logic               anomalous;

    assign scaled     = {{6{reading[15]}}, reading, 4'b0000};
    assign thr        = 26'(mean) * 26'($signed({1'b0, cfg.multiplier}));
    assign over_mean  = scaled > thr;
    assign over_limit = ctrl.learning_open && (limit != 15'd0)
                        && ($signed({reading[15], reading}) > $signed({2'b00, limit}));
    assign anomalous  = over_mean || over_limit;

    always_comb
    begin
        if (anomalous)
        begin
            count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        end
        else
        begin
            count_next = (count_reg == '0) ? count_reg : count_reg - 1'b1;
        end
    end

    always_comb
    begin
        priority if (count_next == '0)
            level_next = sapt_pkg::LEVEL_NONE;
        else if (count_next >= cfg.persistence)
            level_next = sapt_pkg::LEVEL_CONFIRMED;
        else if (count_next >= sapt_pkg::COUNT_W'(2))
            level_next = sapt_pkg::LEVEL_WARNING;
        else
            level_next = sapt_pkg::LEVEL_WATCH;
    end

    // Level as it stands once this item is done.
    assign level = ctrl.update ? level_next : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= sapt_pkg::LEVEL_NONE;
        end
        else if (ctrl.update)
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

### rtl/sapt_message.sv
// Message request with a shared hold time and a per-channel last-send timestamp.
// Depends on sapt_pkg.
module sapt_message
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  sapt_pkg::level_t level,
    input  logic [31:0] now,
    input  logic        delivered,
    input  logic [15:0] hold_seconds,
    output logic        send
);

    logic [31:0] last_reg;
    logic [31:0] since;
    logic        suppressed;

    assign since      = now - last_reg;
    assign suppressed = (last_reg != 32'd0) && (since < {16'd0, hold_seconds});
    assign send       = update && (level == sapt_pkg::LEVEL_CONFIRMED) && !suppressed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 32'd0;
        else if (send && delivered)
            last_reg <= now;
    end

endmodule

### rtl/sensor_alert_persistence_tracker.sv
// Top level of the sensor alert persistence tracker.
// Depends on sapt_pkg, sapt_channel and sapt_message.
//
// One water reading (turbidity, dissolved solids, temperature with their
// seasonal means, fault flags, dry-tank flag, time and delivery flag) goes in
// per transfer and one result comes out per transfer. The block takes one
// item per cycle while results are not stalled: the item lands in an
// input register, the per-channel anomaly test, run count, level and message
// hold are worked out from it and written to the result register together
// with the state update once that register is free. This per-channel logic,
// led by the 16 x 8 mean multiply, sets the clock. The result register parts
// the two sides, so a stalled result only holds off new input once the input
// register is also full.
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle; writes to unused indexes are dropped. The learning window
// length is kept as seconds, scaled at write time.
module sensor_alert_persistence_tracker
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [15:0] turbidity,
    input  logic signed [15:0] solids,
    input  logic signed [15:0] temperature,
    input  logic signed [15:0] turbidity_mean,
    input  logic signed [15:0] solids_mean,
    input  logic signed [15:0] temperature_mean,
    input  logic               turbidity_fault,
    input  logic               solids_fault,
    input  logic               temperature_fault,
    input  logic               tank_empty,
    input  logic [31:0]        time_seconds,
    input  logic               message_delivered,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         overall_level,
    output logic [1:0]         turbidity_level,
    output logic [1:0]         solids_level,
    output logic [1:0]         temperature_level,
    output logic               send_turbidity_message,
    output logic               send_solids_message,
    output logic               learning_active
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    sapt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multiplier   <= sapt_pkg::MULTIPLIER_RESET;
            cfg_reg.persistence  <= sapt_pkg::PERSISTENCE_RESET;
            cfg_reg.hold_seconds <= sapt_pkg::HOLD_RESET;
            cfg_reg.learn_limit  <= sapt_pkg::LEARN_LIMIT_RESET;
            cfg_reg.turb_limit   <= sapt_pkg::TURB_LIMIT_RESET;
            cfg_reg.solids_limit <= sapt_pkg::SOLIDS_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sapt_pkg::REG_MULTIPLIER:   cfg_reg.multiplier   <= cfg_data[7:0];
                sapt_pkg::REG_PERSISTENCE:  cfg_reg.persistence  <= cfg_data[7:0];
                sapt_pkg::REG_HOLD_SECONDS: cfg_reg.hold_seconds <= cfg_data;
                sapt_pkg::REG_LEARN_DAYS:
                    cfg_reg.learn_limit <=
                        sapt_pkg::LEARN_LIMIT_W'(cfg_data[9:0])
                        * sapt_pkg::LEARN_LIMIT_W'(sapt_pkg::SECONDS_PER_DAY);
                sapt_pkg::REG_TURB_LIMIT:   cfg_reg.turb_limit   <= cfg_data[14:0];
                sapt_pkg::REG_SOLIDS_LIMIT: cfg_reg.solids_limit <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic               in_valid_reg;
    logic signed [15:0] turb_reg, solids_reg, temp_reg;
    logic signed [15:0] turb_mean_reg, solids_mean_reg, temp_mean_reg;
    logic               turb_fault_reg, solids_fault_reg, temp_fault_reg;
    logic               dry_reg;
    logic [31:0]        now_reg;
    logic               delivered_reg;

    logic result_load;   // result register free to take an item this cycle
    logic advance;       // input register hands its item on
    logic item_take;

    assign result_load = !result_valid || !result_stall;
    assign advance     = in_valid_reg && result_load;
    assign item_stall  = in_valid_reg && !result_load;
    assign item_take   = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            turb_reg         <= turbidity;
            solids_reg       <= solids;
            temp_reg         <= temperature;
            turb_mean_reg    <= turbidity_mean;
            solids_mean_reg  <= solids_mean;
            temp_mean_reg    <= temperature_mean;
            turb_fault_reg   <= turbidity_fault;
            solids_fault_reg <= solids_fault;
            temp_fault_reg   <= temperature_fault;
            dry_reg          <= tank_empty;
            now_reg          <= time_seconds;
            delivered_reg    <= message_delivered;
        end
    end

    // ---------------------------------------------------------------
    // Learning window: the first item marks the start; the window closes
    // once the elapsed time reaches the configured number of days and
    // stays closed until reset.
    // ---------------------------------------------------------------
    logic        learn_open_reg;
    logic        learn_begun_reg;
    logic [31:0] learn_start_reg;
    logic [31:0] start_eff;
    logic [31:0] elapsed;
    logic        learn_open_now;

    assign start_eff      = learn_begun_reg ? learn_start_reg : now_reg;
    assign elapsed        = now_reg - start_eff;
    assign learn_open_now = learn_open_reg
                            && (elapsed < {{(32 - sapt_pkg::LEARN_LIMIT_W){1'b0}},
                                           cfg_reg.learn_limit});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_open_reg  <= 1'b1;
            learn_begun_reg <= 1'b0;
            learn_start_reg <= 32'd0;
        end
        else if (advance && learn_open_reg)
        begin
            learn_open_reg  <= learn_open_now;
            learn_begun_reg <= 1'b1;
            learn_start_reg <= start_eff;
        end
    end

    // ---------------------------------------------------------------
    // Channels
    // ---------------------------------------------------------------
    sapt_pkg::chan_ctrl_t turb_ctrl, solids_ctrl, temp_ctrl;
    sapt_pkg::level_t     turb_lvl, solids_lvl, temp_lvl;
    logic                 turb_send, solids_send;

    assign turb_ctrl.update          = advance && !dry_reg && !turb_fault_reg;
    assign turb_ctrl.learning_open   = learn_open_now;
    assign solids_ctrl.update        = advance && !dry_reg && !solids_fault_reg;
    assign solids_ctrl.learning_open = learn_open_now;
    assign temp_ctrl.update          = advance && !dry_reg && !temp_fault_reg;
    assign temp_ctrl.learning_open   = learn_open_now;

    sapt_channel u_turb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (turb_ctrl),
        .cfg     (cfg_reg),
        .limit   (cfg_reg.turb_limit),
        .reading (turb_reg),
        .mean    (turb_mean_reg),
        .level   (turb_lvl)
    );

    sapt_channel u_solids
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (solids_ctrl),
        .cfg     (cfg_reg),
        .limit   (cfg_reg.solids_limit),
        .reading (solids_reg),
        .mean    (solids_mean_reg),
        .level   (solids_lvl)
    );

    // Temperature has no fallback limit.
    sapt_channel u_temp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (temp_ctrl),
        .cfg     (cfg_reg),
        .limit   (15'd0),
        .reading (temp_reg),
        .mean    (temp_mean_reg),
        .level   (temp_lvl)
    );

    sapt_message u_turb_msg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (turb_ctrl.update),
        .level        (turb_lvl),
        .now          (now_reg),
        .delivered    (delivered_reg),
        .hold_seconds (cfg_reg.hold_seconds),
        .send         (turb_send)
    );

    sapt_message u_solids_msg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (solids_ctrl.update),
        .level        (solids_lvl),
        .now          (now_reg),
        .delivered    (delivered_reg),
        .hold_seconds (cfg_reg.hold_seconds),
        .send         (solids_send)
    );

    // Highest level among the channels updated by this item.
    logic [1:0] turb_part, solids_part, temp_part, max_ts, overall_next;

    assign turb_part    = turb_ctrl.update   ? turb_lvl   : sapt_pkg::LEVEL_NONE;
    assign solids_part  = solids_ctrl.update ? solids_lvl : sapt_pkg::LEVEL_NONE;
    assign temp_part    = temp_ctrl.update   ? temp_lvl   : sapt_pkg::LEVEL_NONE;
    assign max_ts       = (turb_part > solids_part) ? turb_part : solids_part;
    assign overall_next = (max_ts > temp_part) ? max_ts : temp_part;

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (result_load)
            result_valid <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            overall_level          <= overall_next;
            turbidity_level        <= turb_lvl;
            solids_level           <= solids_lvl;
            temperature_level      <= temp_lvl;
            send_turbidity_message <= turb_send;
            send_solids_message    <= solids_send;
            learning_active        <= learn_open_now;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_learning_stays_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !learn_open_reg |=> !learn_open_reg)
        else $error("learning window reopened");

    a_turb_send_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && send_turbidity_message)
        |-> (turbidity_level == sapt_pkg::LEVEL_CONFIRMED))
        else $error("turbidity message requested below confirmed level");

    a_solids_send_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && send_solids_message)
        |-> (solids_level == sapt_pkg::LEVEL_CONFIRMED))
        else $error("solids message requested below confirmed level");

    a_overall_from_channel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (overall_level == sapt_pkg::LEVEL_NONE
                          || overall_level == turbidity_level
                          || overall_level == solids_level
                          || overall_level == temperature_level))
        else $error("overall level matches no channel");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for sensor_alert_persistence_tracker: directed and random readings,
// predicted by a scoreboard class and checked on every result transfer.
// Depends on sapt_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module tb;
    import sapt_pkg::*;

    // Back-pressure patterns applied to the two channels during a phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Indexes beyond the register file; writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam int HOLD_OFF_CYCLES = 120;

    // Channel order in both structs: 0 turbidity, 1 dissolved solids, 2 temperature
    typedef struct packed {
        logic [2:0][15:0] value;
        logic [2:0][15:0] mean;
        logic [2:0]       fault;
        logic             dry;
        logic [31:0]      now;
        logic             delivered;
    } water_item_t;

    typedef struct packed {
        logic [1:0] overall;
        logic [1:0] turb;
        logic [1:0] solids;
        logic [1:0] temp;
        logic       send_turb;
        logic       send_solids;
        logic       learning;
    } alert_result_t;

    // Scoreboard: keeps its own copy of the tracker state, works out the alert that
    // each accepted reading must produce and checks results in arrival order.
    class alert_scoreboard;
        bit [7:0]      mult;
        bit [7:0]      persist;
        bit [15:0]     hold;
        bit [9:0]      days;
        bit [14:0]     turb_limit;
        bit [14:0]     solids_limit;
        bit            learn_open;
        bit            learn_begun;
        bit [31:0]     learn_start;
        bit [7:0]      run_len [3];
        level_t        level [3];
        bit [31:0]     last_sent [2];
        alert_result_t due_alerts [$];
        int            mismatches;

        function new();
            mult         = MULTIPLIER_RESET;
            persist      = PERSISTENCE_RESET;
            hold         = HOLD_RESET;
            days         = 10'd30;
            turb_limit   = TURB_LIMIT_RESET;
            solids_limit = SOLIDS_LIMIT_RESET;
            learn_open   = 1'b1;
            learn_begun  = 1'b0;
            learn_start  = '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                run_len[ch] = '0;
                level[ch]   = LEVEL_NONE;
            end
            last_sent[0] = '0;
            last_sent[1] = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_MULTIPLIER:   mult         = data[7:0];
                REG_PERSISTENCE:  persist      = data[7:0];
                REG_HOLD_SECONDS: hold         = data;
                REG_LEARN_DAYS:   days         = data[9:0];
                REG_TURB_LIMIT:   turb_limit   = data[14:0];
                REG_SOLIDS_LIMIT: solids_limit = data[14:0];
                default:          ;
            endcase
        endfunction

        // Reading above mean times multiplier (multiplier in sixteenths), or above a live fallback limit
        function bit over_limit(logic [15:0] reading, logic [15:0] mean, bit [14:0] limit);
            longint r;
            longint m;
            longint k;
            longint lim;
            r   = $signed(reading);
            m   = $signed(mean);
            k   = mult;
            lim = limit;
            if (r * 16 > m * k)
                return 1'b1;
            return learn_open && lim != 0 && r > lim;
        endfunction

        function bit request_message(int ch, logic [31:0] now, logic delivered);
            bit [31:0] since;
            if (level[ch] != LEVEL_CONFIRMED)
                return 1'b0;
            since = now - last_sent[ch];
            if (last_sent[ch] != 0 && since < {16'd0, hold})
                return 1'b0;
            if (delivered)
                last_sent[ch] = now;
            return 1'b1;
        endfunction

        function void note_reading(water_item_t w);
            alert_result_t want;
            bit [31:0]     elapsed;
            bit [14:0]     limit;
            bit            hot;
            bit            sent;
            level_t        top;
            want = '0;
            top  = LEVEL_NONE;
            if (learn_open)
            begin
                if (!learn_begun)
                begin
                    learn_begun = 1'b1;
                    learn_start = w.now;
                end
                elapsed = w.now - learn_start;
                if (elapsed / SECONDS_PER_DAY >= days)
                    learn_open = 1'b0;
            end
            if (!w.dry)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (!w.fault[ch])
                    begin
                        limit = (ch == 0) ? turb_limit : (ch == 1) ? solids_limit : 15'd0;
                        hot   = over_limit(w.value[ch], w.mean[ch], limit);
                        if (hot && run_len[ch] != 8'hFF)
                            run_len[ch]++;
                        else if (!hot && run_len[ch] != 0)
                            run_len[ch]--;
                        if (run_len[ch] == 0)
                            level[ch] = LEVEL_NONE;
                        else if (run_len[ch] >= persist)
                            level[ch] = LEVEL_CONFIRMED;
                        else if (run_len[ch] >= 2)
                            level[ch] = LEVEL_WARNING;
                        else
                            level[ch] = LEVEL_WATCH;
                        if (ch < 2)
                        begin
                            sent = request_message(ch, w.now, w.delivered);
                            if (ch == 0)
                                want.send_turb = sent;
                            else
                                want.send_solids = sent;
                        end
                        if (level[ch] > top)
                            top = level[ch];
                    end
                end
            end
            want.overall  = top;
            want.turb     = level[0];
            want.solids   = level[1];
            want.temp     = level[2];
            want.learning = learn_open;
            due_alerts.push_back(want);
        endfunction

        function string alert_text(alert_result_t a);
            return $sformatf("overall %0d levels %0d/%0d/%0d send %b%b learning %b",
                             a.overall, a.turb, a.solids, a.temp,
                             a.send_turb, a.send_solids, a.learning);
        endfunction

        function void check_alert(alert_result_t got);
            alert_result_t want;
            if (due_alerts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: result with none due: %s", $realtime,
                             alert_text(got));
                return;
            end
            want = due_alerts.pop_front();
            if (got.overall !== want.overall || got.turb !== want.turb ||
                got.solids !== want.solids || got.temp !== want.temp ||
                got.send_turb !== want.send_turb || got.send_solids !== want.send_solids ||
                got.learning !== want.learning)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %s, got %s", $realtime,
                             alert_text(want), alert_text(got));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n             = 1'b0;
    logic               cfg_write         = 1'b0;
    logic [2:0]         cfg_index         = REG_MULTIPLIER;
    logic [15:0]        cfg_data          = '0;
    logic               item_valid        = 1'b0;
    logic               item_stall;
    logic signed [15:0] turbidity         = '0;
    logic signed [15:0] solids            = '0;
    logic signed [15:0] temperature       = '0;
    logic signed [15:0] turbidity_mean    = '0;
    logic signed [15:0] solids_mean       = '0;
    logic signed [15:0] temperature_mean  = '0;
    logic               turbidity_fault   = 1'b0;
    logic               solids_fault      = 1'b0;
    logic               temperature_fault = 1'b0;
    logic               tank_empty        = 1'b0;
    logic [31:0]        time_seconds      = '0;
    logic               message_delivered = 1'b0;
    logic               result_valid;
    logic               result_stall      = 1'b0;
    logic [1:0]         overall_level;
    logic [1:0]         turbidity_level;
    logic [1:0]         solids_level;
    logic [1:0]         temperature_level;
    logic               send_turbidity_message;
    logic               send_solids_message;
    logic               learning_active;

    alert_scoreboard sb;

    // Pacing and stimulus mix, set per phase by the main sequence
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_starts   = 0;
    int          hot_pct       = 50;
    int          fault_pct     = 5;
    int          dry_pct       = 5;
    int unsigned max_step      = 600;
    logic [31:0] now_t         = 32'd1000;

    sensor_alert_persistence_tracker u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: check every transfer, then pick the stall for the next cycle.
    // A bump of hold_starts makes this process hold off for a long stretch so the
    // block fills up and has to stall its input.
    initial
    begin
        alert_result_t got;
        int            hold_left;
        int            hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                got.overall     = overall_level;
                got.turb        = turbidity_level;
                got.solids      = solids_level;
                got.temp        = temperature_level;
                got.send_turb   = send_turbidity_message;
                got.send_solids = send_solids_message;
                got.learning    = learning_active;
                sb.check_alert(got);
            end
            if (hold_seen != hold_starts)
            begin
                hold_seen = hold_starts;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic set_idle(idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 34 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 34 : 0;
    endtask

    task automatic set_mix(int hot, int fault, int dry, int unsigned step);
        hot_pct   = hot;
        fault_pct = fault;
        dry_pct   = dry;
        max_step  = step;
    endtask

    // One register write per cycle; the caller lowers cfg_write afterwards
    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_config(bit [7:0] m, bit [7:0] p, bit [15:0] h, bit [9:0] d,
                                bit [14:0] tl, bit [14:0] sl);
        write_reg(REG_MULTIPLIER, {8'd0, m});
        write_reg(REG_PERSISTENCE, {8'd0, p});
        write_reg(REG_HOLD_SECONDS, h);
        write_reg(REG_LEARN_DAYS, {6'd0, d});
        write_reg(REG_TURB_LIMIT, {1'b0, tl});
        write_reg(REG_SOLIDS_LIMIT, {1'b0, sl});
        cfg_write <= 1'b0;
    endtask

    // Offer one reading after a random gap and hold it until the transfer
    task automatic push_item(water_item_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid        <= 1'b1;
        turbidity         <= w.value[0];
        solids            <= w.value[1];
        temperature       <= w.value[2];
        turbidity_mean    <= w.mean[0];
        solids_mean       <= w.mean[1];
        temperature_mean  <= w.mean[2];
        turbidity_fault   <= w.fault[0];
        solids_fault      <= w.fault[1];
        temperature_fault <= w.fault[2];
        tank_empty        <= w.dry;
        time_seconds      <= w.now;
        message_delivered <= w.delivered;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_reading(w);
    endtask

    task automatic send_fixed(logic [15:0] t, logic [15:0] s, logic [15:0] c,
                              logic [15:0] tm, logic [15:0] sm, logic [15:0] cm,
                              logic [2:0] fault, logic dry, int unsigned dt, logic deliv);
        water_item_t w;
        now_t       = now_t + dt;
        w.value[0]  = t;
        w.value[1]  = s;
        w.value[2]  = c;
        w.mean[0]   = tm;
        w.mean[1]   = sm;
        w.mean[2]   = cm;
        w.fault     = fault;
        w.dry       = dry;
        w.now       = now_t;
        w.delivered = deliv;
        push_item(w);
    endtask

    // Place a reading just above or at/below the scaled mean under the live multiplier,
    // now and then anywhere in the full range
    function automatic logic [15:0] pick_reading(logic [15:0] mean, bit hot);
        longint m;
        longint k;
        longint edge_v;
        longint d;
        longint v;
        if ($urandom_range(99) < 12)
            return 16'($urandom);
        m      = $signed(mean);
        k      = sb.mult;
        edge_v = (m * k) >>> 4;
        if (hot)
        begin
            d = $urandom_range(60, 1);
            v = edge_v + d;
        end
        else
        begin
            d = $urandom_range(60, 0);
            v = edge_v - d;
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic send_random();
        water_item_t w;
        for (int ch = 0; ch < 3; ch++)
        begin
            w.mean[ch]  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(700, 0));
            w.value[ch] = pick_reading(w.mean[ch], $urandom_range(99) < hot_pct);
            w.fault[ch] = ($urandom_range(99) < fault_pct);
        end
        w.dry = ($urandom_range(99) < dry_pct);
        // Jump time about freely only once the learning window is shut for good
        if (!sb.learn_open && $urandom_range(99) < 3)
            now_t = $urandom;
        else
            now_t = now_t + $urandom_range(max_step, 0);
        w.now       = now_t;
        w.delivered = ($urandom_range(99) < 70);
        push_item(w);
    endtask

    // squeeze_at > 0 starts a long receiver hold-off at that item
    task automatic run_random(int count, int squeeze_at);
        for (int i = 0; i < count; i++)
        begin
            if (squeeze_at > 0 && i == squeeze_at)
                hold_starts++;
            send_random();
        end
    endtask

    // Drop valid and drain: every reading gives one result, so an empty queue means idle
    task automatic finish_phase();
        item_valid <= 1'b0;
        while (sb.due_alerts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned whole_days;
        logic [31:0] edge_time;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset configuration, no idling.
        // The first reading opens the learning window at time 1000.
        set_idle(IDLE_NONE);
        send_fixed(0, 0, 0, 0, 0, 0, 3'b000, 1'b0, 0, 1'b1);
        // Field extremes: highest readings over lowest means and the other way round
        send_fixed(32767, 32767, 32767, -32768, -32768, -32768, 3'b000, 1'b0, 10, 1'b1);
        send_fixed(-32768, -32768, -32768, 32767, 32767, 32767, 3'b000, 1'b0, 10, 1'b1);
        // Build a run of three to confirm; the third requests and delivers both messages
        repeat (3) send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b000, 1'b0, 10, 1'b1);
        // Still within the hold time: requests suppressed
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b000, 1'b0, 100, 1'b1);
        // Dry tank leaves everything untouched
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b000, 1'b1, 10, 1'b1);
        // Faulty channels are skipped
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b111, 1'b0, 10, 1'b1);
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b001, 1'b0, 10, 1'b1);
        // Hold time over: request but no delivery, so the next one asks again
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b000, 1'b0, 3600, 1'b0);
        send_fixed(32767, 32767, 32767, 0, 0, 0, 3'b000, 1'b0, 1, 1'b1);
        // Fallback limits during learning: one above, then exactly at the limit
        send_fixed(81, 16001, 0, 32767, 32767, 0, 3'b000, 1'b0, 5, 1'b0);
        send_fixed(80, 16000, 0, 32767, 32767, 0, 3'b000, 1'b0, 5, 1'b0);
        // Temperature exactly at and just above the scaled mean
        send_fixed(0, 0, 300, 0, 0, 100, 3'b000, 1'b0, 5, 1'b0);
        send_fixed(0, 0, 301, 0, 0, 100, 3'b000, 1'b0, 5, 1'b0);
        // Negative means: above, then at the scaled mean
        send_fixed(-10, -10, -10, -4, -4, -4, 3'b000, 1'b0, 5, 1'b1);
        send_fixed(-12, -12, -12, -4, -4, -4, 3'b000, 1'b0, 5, 1'b1);
        finish_phase();

        // Longest learning window, default thresholds, steady flow
        apply_config(8'd48, 8'd3, 16'd3600, 10'd1023, 15'd80, 15'd16000);
        set_mix(60, 5, 5, 600);
        run_random(250, 0);
        finish_phase();

        // Highest multiplier and persistence, no hold time, limits at top:
        // mostly anomalies so the run counts saturate
        apply_config(8'd255, 8'd255, 16'd0, 10'd1023, 15'd32767, 15'd32767);
        set_idle(IDLE_SENDER);
        set_mix(97, 1, 1, 200);
        run_random(360, 0);
        finish_phase();

        // Zero multiplier, persistence of two, longest hold, limits disabled;
        // receiver stalls and holds off once for a long stretch
        apply_config(8'd0, 8'd2, 16'd65535, 10'd500, 15'd0, 15'd0);
        set_idle(IDLE_RECEIVER);
        set_mix(50, 5, 5, 3000);
        run_random(250, 40);
        finish_phase();

        // Shut the learning window at its exact boundary: one second short, then on it
        whole_days = (now_t - sb.learn_start) / SECONDS_PER_DAY;
        write_reg(REG_LEARN_DAYS, 16'(whole_days + 1));
        cfg_write <= 1'b0;
        edge_time = sb.learn_start + (whole_days + 1) * SECONDS_PER_DAY;
        send_fixed(100, 100, 100, 0, 0, 0, 3'b000, 1'b0, edge_time - 1 - now_t, 1'b1);
        send_fixed(100, 100, 100, 0, 0, 0, 3'b000, 1'b0, 1, 1'b1);
        finish_phase();

        // Window closed: unity multiplier, persistence of one, zero learning days
        apply_config(8'd16, 8'd1, 16'd100, 10'd0, 15'd1, 15'd32767);
        set_idle(IDLE_BOTH);
        set_mix(40, 10, 8, 150);
        run_random(250, 0);
        finish_phase();

        // Spare indexes must be ignored; persistence of zero; time wraps past 2^32
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'hFFFF);
        apply_config(8'd200, 8'd0, 16'd1000, 10'd0, 15'd0, 15'd1);
        set_idle(IDLE_SENDER);
        set_mix(55, 5, 5, 300);
        now_t = 32'hFFFF_8000;
        run_random(250, 0);
        // Deliver a message at time zero: it reads back as never sent
        now_t = 32'hFFFF_FFFD;
        send_fixed(32767, 32767, 0, 0, 0, 0, 3'b000, 1'b0, 1, 1'b0);
        send_fixed(32767, 32767, 0, 0, 0, 0, 3'b000, 1'b0, 1, 1'b0);
        send_fixed(32767, 32767, 0, 0, 0, 0, 3'b000, 1'b0, 1, 1'b1);
        send_fixed(32767, 32767, 0, 0, 0, 0, 3'b000, 1'b0, 1, 1'b1);
        send_fixed(32767, 32767, 0, 0, 0, 0, 3'b000, 1'b0, 1, 1'b1);
        finish_phase();

        // Back to the reset values, both sides idling, another long hold-off
        apply_config(MULTIPLIER_RESET, PERSISTENCE_RESET, HOLD_RESET, 10'd30,
                     TURB_LIMIT_RESET, SOLIDS_LIMIT_RESET);
        set_idle(IDLE_BOTH);
        set_mix(55, 5, 5, 2000);
        run_random(400, 100);
        finish_phase();

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.due_alerts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
